/* rtl/touch_codec_digitizer_regs_defines.svh */
// ----------------------------------------------------------------------------
// touch codec digitizer assertion macros
// shared property forms used by the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef TOUCH_CODEC_DIGITIZER_REGS_DEFINES_SVH
`define TOUCH_CODEC_DIGITIZER_REGS_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdr check failed");

// next-cycle implication, disabled while in reset
`define TDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdr check failed");

`endif

/* rtl/tdr_pkg.sv */
// ----------------------------------------------------------------------------
// tdr_pkg
// types, constants and helpers for the touch codec register file
// ----------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int VREF_MV     = 3300;
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    localparam sample_t SAMPLE_FULL = '1;

    // aux conversion: round(mv * full_scale / vref) by reciprocal multiply
    localparam int AUX_HALF  = VREF_MV / 2;
    localparam int PROD_W    = 16 + SAMPLE_BITS;
    localparam int NUM_W     = $clog2(VREF_MV * (FULL_SCALE + 1));
    localparam int VREF_W    = $clog2(VREF_MV + 1);
    localparam int DIV_SHIFT = NUM_W + VREF_W;
    localparam int RECIP_W   = DIV_SHIFT - VREF_W + 2;
    localparam logic [RECIP_W-1:0] AUX_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(VREF_MV) - 64'd1) / 64'(VREF_MV));

    localparam int NREGS          = 26;
    localparam int SLOT_W         = $clog2(NREGS);
    localparam int GPIOSHARE_SLOT = 22;
    localparam int GPIO_PEN_SHARE = 3;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_TICK  = 3'd2,
        OP_PEN   = 3'd3,
        OP_AUX   = 3'd4
    } op_t;

    // fixed and digitizer register addresses
    localparam logic [6:0] ADDR_RESET  = 7'h00;
    localparam logic [6:0] ADDR_EXT_ID = 7'h28;
    localparam logic [6:0] ADDR_DIG1   = 7'h76;
    localparam logic [6:0] ADDR_DIG2   = 7'h78;
    localparam logic [6:0] ADDR_DIGRES = 7'h7a;
    localparam logic [6:0] ADDR_VID1   = 7'h7c;
    localparam logic [6:0] ADDR_VID2   = 7'h7e;

    localparam logic [15:0] RESET_ID_VAL = 16'h6174;
    localparam logic [15:0] EXT_ID_VAL   = 16'h0405;
    localparam logic [15:0] VID1_VAL     = 16'h574D;
    localparam logic [15:0] VID2_VAL     = 16'h4C12;

    // digitizer control one bits
    localparam int DIG1_POLL      = 15;
    localparam int DIG1_CH_LSB    = 12;
    localparam int DIG1_XY        = 11;
    localparam int DIG1_CONT      = 10;
    localparam int DIG1_SLOT_MODE = 3;
    // digitizer control two bits
    localparam int DIG2_PEN_DET   = 11;
    localparam int DIG2_WAIT      = 9;

    localparam logic [2:0] CH_NONE = 3'd0;
    localparam logic [2:0] CH_X    = 3'd1;
    localparam logic [2:0] CH_Y    = 3'd2;
    localparam logic [2:0] CH_PRES = 3'd3;

    localparam logic [6:0] REG_ADDRS [NREGS] = '{
        7'h02, 7'h04, 7'h06, 7'h0a, 7'h0e, 7'h10, 7'h14, 7'h16, 7'h18, 7'h1a,
        7'h1c, 7'h24, 7'h26, 7'h2a, 7'h2c, 7'h2e, 7'h32, 7'h4c, 7'h4e, 7'h50,
        7'h52, 7'h54, 7'h56, 7'h58, 7'h5a, 7'h5c};

    localparam logic [15:0] REG_DEFAULTS [NREGS] = '{
        16'h8000, 16'h8000, 16'h8000, 16'hc008, 16'h6808, 16'he808, 16'had00,
        16'h8000, 16'he808, 16'h3000, 16'h8000, 16'h0000, 16'h0000, 16'h0410,
        16'hbb80, 16'hbb80, 16'hbb80, 16'hf83e, 16'hffff, 16'h0000, 16'h0000,
        16'h0000, 16'hf83e, 16'h0008, 16'h0000, 16'h0000};

    // channel index in bits 14-12, sample in 11-0
    typedef logic [14:0] dig_word_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_lookup_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [6:0]        reg_addr;
        logic [15:0]       write_data;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic signed [15:0] pen_press;
        logic [1:0]        aux_pin;
        logic              aux_sat;
        logic [NUM_W-1:0]  aux_num;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        read_ok;
        logic        slot_valid;
        logic [15:0] slot_data;
        logic        pen_pin_level;
    } result_t;

    // addresses in the table are distinct, so the matches can be or-ed
    function automatic slot_lookup_t find_slot(input logic [6:0] addr);
        slot_lookup_t r;
        r = '0;
        for (int i = 0; i < NREGS; i++)
        begin
            if (REG_ADDRS[i] == addr)
            begin
                r.hit = 1'b1;
                r.idx = r.idx | SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/tdr_if.sv */
// ----------------------------------------------------------------------------
// tdr_if
// item and result channels of the touch codec register file
// ----------------------------------------------------------------------------
`default_nettype none

interface tdr_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [6:0]         reg_addr;
    logic [15:0]        write_data;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic signed [15:0] pen_press;
    logic [1:0]         aux_pin;
    logic [15:0]        aux_millivolts;

    modport source (
        output valid, op, reg_addr, write_data, pen_x, pen_y, pen_press,
               aux_pin, aux_millivolts,
        input  ready
    );
    modport sink (
        input  valid, op, reg_addr, write_data, pen_x, pen_y, pen_press,
               aux_pin, aux_millivolts,
        output ready
    );
endinterface

interface tdr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        read_ok;
    logic        slot_valid;
    logic [15:0] slot_data;
    logic        pen_pin_level;

    modport source (
        output valid, read_data, read_ok, slot_valid, slot_data, pen_pin_level,
        input  ready
    );
    modport sink (
        input  valid, read_data, read_ok, slot_valid, slot_data, pen_pin_level,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/tdr_in_stage.sv */
// ----------------------------------------------------------------------------
// tdr_in_stage
// input register, also forms the aux conversion numerator
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_in_stage
    import tdr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tdr_in_if.sink    req,
    input  wire logic advance,
    output logic      valid,
    output item_t     item
);

    logic        valid_reg;
    logic        valid_next;
    item_t       item_reg;
    logic        accept;
    logic [PROD_W-1:0] aux_prod;

    assign req.ready = !valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign aux_prod = PROD_W'(req.aux_millivolts) * PROD_W'(FULL_SCALE)
                    + PROD_W'(AUX_HALF);

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op         <= req.op;
            item_reg.reg_addr   <= req.reg_addr;
            item_reg.write_data <= req.write_data;
            item_reg.pen_x      <= req.pen_x;
            item_reg.pen_y      <= req.pen_y;
            item_reg.pen_press  <= req.pen_press;
            item_reg.aux_pin    <= req.aux_pin;
            item_reg.aux_sat    <= req.aux_millivolts > 16'(VREF_MV);
            item_reg.aux_num    <= NUM_W'(aux_prod);
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

/* rtl/tdr_core.sv */
// ----------------------------------------------------------------------------
// tdr_core
// codec register store, digitizer state and per-item update logic
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_codec_digitizer_regs_defines.svh"

module tdr_core
    import tdr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire logic  pen_pin_enable,
    output result_t    result
);

    logic [15:0] store_reg [NREGS];
    logic [15:0] store_next [NREGS];
    logic [15:0] dig1_reg, dig1_next;
    logic [15:0] dig2_reg, dig2_next;
    dig_word_t   dig_res_reg, dig_res_next;
    sample_t     samples_reg [3];
    sample_t     samples_next [3];
    logic        pen_down_reg, pen_down_next;
    sample_t     aux_reg [4];
    sample_t     aux_next [4];
    logic        unread_reg, unread_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    dig_word_t   pend_reg [2];
    dig_word_t   pend_next [2];

    slot_lookup_t lookup;
    logic [NUM_W+RECIP_W-1:0] aux_quot_prod;
    sample_t     aux_level;
    logic        pen_up;
    logic        tick_blocked;
    logic        tick_hit;
    dig_word_t   tick_word;
    logic [2:0]  tick_ch;
    dig_word_t   word_x, word_y, word_ch;

    function automatic dig_word_t chan_word(
        input logic [2:0] ch,
        input sample_t    s [3],
        input sample_t    a [4]
    );
        sample_t v;
        v = '0;
        unique case (ch)
            CH_NONE: v = '0;
            CH_X:    v = s[0];
            CH_Y:    v = s[1];
            CH_PRES: v = s[2];
            default: v = a[ch[1:0]];
        endcase
        return {ch, 12'(v)};
    endfunction

    assign lookup        = find_slot(item.reg_addr);
    assign aux_quot_prod = (NUM_W+RECIP_W)'(item.aux_num) * (NUM_W+RECIP_W)'(AUX_RECIP);
    assign aux_level     = item.aux_sat ? SAMPLE_FULL : SAMPLE_BITS'(aux_quot_prod >> DIV_SHIFT);
    assign pen_up        = item.pen_x[15] || item.pen_y[15] || item.pen_press[15];

    assign tick_ch = dig1_reg[DIG1_CH_LSB +: 3];
    assign word_x  = chan_word(CH_X, samples_reg, aux_reg);
    assign word_y  = chan_word(CH_Y, samples_reg, aux_reg);
    assign word_ch = chan_word(tick_ch, samples_reg, aux_reg);

    // register mode waits for the result read if asked; slot mode for slot 0
    assign tick_blocked =
        (!dig1_reg[DIG1_SLOT_MODE] && unread_reg && dig2_reg[DIG2_WAIT]) ||
        (dig1_reg[DIG1_SLOT_MODE] && (dig1_reg[2:0] != 3'd0));

    always_comb
    begin
        store_next    = store_reg;
        dig1_next     = dig1_reg;
        dig2_next     = dig2_reg;
        dig_res_next  = dig_res_reg;
        samples_next  = samples_reg;
        pen_down_next = pen_down_reg;
        aux_next      = aux_reg;
        unread_next   = unread_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_next     = pend_reg;
        tick_hit      = 1'b0;
        tick_word     = '0;
        result        = '0;

        if (fire)
        begin
            unique case (item.op)
                OP_READ:
                begin
                    result.read_ok = 1'b1;
                    if (lookup.hit)
                    begin
                        result.read_data = store_reg[lookup.idx];
                    end
                    else
                    begin
                        unique case (item.reg_addr)
                            ADDR_RESET:  result.read_data = RESET_ID_VAL;
                            ADDR_EXT_ID: result.read_data = EXT_ID_VAL;
                            ADDR_DIG1:   result.read_data = dig1_reg;
                            ADDR_DIG2:   result.read_data = dig2_reg;
                            ADDR_DIGRES:
                            begin
                                result.read_data = {pen_down_reg, dig_res_reg};
                                unread_next      = 1'b0;
                            end
                            ADDR_VID1:   result.read_data = VID1_VAL;
                            ADDR_VID2:   result.read_data = VID2_VAL;
                            default:     result.read_ok   = 1'b0;
                        endcase
                    end
                end
                OP_WRITE:
                begin
                    if (lookup.hit)
                    begin
                        store_next[lookup.idx] = item.write_data;
                    end
                    else if (item.reg_addr == ADDR_DIG1)
                    begin
                        dig1_next = item.write_data;
                    end
                    else if (item.reg_addr == ADDR_DIG2)
                    begin
                        dig2_next = item.write_data;
                    end
                end
                OP_TICK:
                begin
                    if (!tick_blocked)
                    begin
                        priority if (pend_cnt_reg == 2'd2 || pend_cnt_reg == 2'd1)
                        begin
                            // queued words go out in order y then third channel
                            tick_hit      = 1'b1;
                            tick_word     = pend_cnt_reg[1] ? pend_reg[0] : pend_reg[1];
                            pend_cnt_next = pend_cnt_reg - 2'd1;
                        end
                        else if (dig1_reg[DIG1_POLL] || (dig1_reg[DIG1_CONT] &&
                                 (pen_down_reg || !dig2_reg[DIG2_PEN_DET])))
                        begin
                            tick_hit             = 1'b1;
                            dig1_next[DIG1_POLL] = 1'b0;
                            if (dig1_reg[DIG1_XY])
                            begin
                                tick_word = word_x;
                                if (tick_ch != CH_NONE)
                                begin
                                    pend_next[0]  = word_y;
                                    pend_next[1]  = word_ch;
                                    pend_cnt_next = 2'd2;
                                end
                                else
                                begin
                                    pend_next[1]  = word_y;
                                    pend_cnt_next = 2'd1;
                                end
                            end
                            else
                            begin
                                tick_word = word_ch;
                            end
                        end
                        else
                        begin
                            tick_hit = 1'b0;
                        end

                        if (tick_hit)
                        begin
                            if (dig1_reg[DIG1_SLOT_MODE])
                            begin
                                result.slot_valid = 1'b1;
                                result.slot_data  = {pen_down_reg, tick_word};
                            end
                            else
                            begin
                                dig_res_next = tick_word;
                                unread_next  = 1'b1;
                            end
                        end
                    end
                end
                OP_PEN:
                begin
                    samples_next[0] = pen_up ? SAMPLE_FULL : item.pen_x[SAMPLE_BITS-1:0];
                    samples_next[1] = pen_up ? SAMPLE_FULL : item.pen_y[SAMPLE_BITS-1:0];
                    samples_next[2] = pen_up ? '0 : item.pen_press[SAMPLE_BITS-1:0];
                    pen_down_next   = !pen_up;
                end
                OP_AUX:
                begin
                    aux_next[item.aux_pin] = aux_level;
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end

        result.pen_pin_level = pen_pin_enable &&
                               !store_next[GPIOSHARE_SLOT][GPIO_PEN_SHARE] &&
                               pen_down_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                store_reg[i] <= REG_DEFAULTS[i];
            end
            dig1_reg     <= '0;
            dig2_reg     <= '0;
            dig_res_reg  <= '0;
            samples_reg  <= '{default: '0};
            pen_down_reg <= 1'b0;
            aux_reg      <= '{default: '0};
            unread_reg   <= 1'b0;
            pend_cnt_reg <= '0;
            pend_reg     <= '{default: '0};
        end
        else
        begin
            store_reg    <= store_next;
            dig1_reg     <= dig1_next;
            dig2_reg     <= dig2_next;
            dig_res_reg  <= dig_res_next;
            samples_reg  <= samples_next;
            pen_down_reg <= pen_down_next;
            aux_reg      <= aux_next;
            unread_reg   <= unread_next;
            pend_cnt_reg <= pend_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    `TDR_ASSERT_IMP(a_pend_cnt_range, clk, rst_n, 1'b1, pend_cnt_reg != 2'd3)
    `TDR_ASSERT_IMP(a_slot_from_tick, clk, rst_n, result.slot_valid, fire && item.op == OP_TICK)
    `TDR_ASSERT_IMP(a_slot_pen_bit, clk, rst_n, result.slot_valid, result.slot_data[15] == pen_down_reg)
    `TDR_ASSERT_NXT(a_res_read_clears, clk, rst_n, fire && item.op == OP_READ && item.reg_addr == ADDR_DIGRES, !unread_reg)

endmodule

`default_nettype wire

/* rtl/tdr_out_stage.sv */
// ----------------------------------------------------------------------------
// tdr_out_stage
// result register holding one finished item until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_out_stage
    import tdr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tdr_out_if.source    rsp,
    input  wire logic    load,
    input  wire result_t result,
    output logic         free
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.read_data     = result_reg.read_data;
    assign rsp.read_ok       = result_reg.read_ok;
    assign rsp.slot_valid    = result_reg.slot_valid;
    assign rsp.slot_data     = result_reg.slot_data;
    assign rsp.pen_pin_level = result_reg.pen_pin_level;

endmodule

`default_nettype wire

/* rtl/touch_codec_digitizer_regs.sv */
// ----------------------------------------------------------------------------
// touch_codec_digitizer_regs
// codec register file with touch digitizer, apb configuration port
// ----------------------------------------------------------------------------
// One item per clock cycle while the result side takes results, through an
// input register, then update logic that writes all state and the result
// register together. The rate is set by that state update; the aux voltage
// conversion is split into one multiplier in front of the input register and
// one behind it. A result is produced for every item, and the next item is
// taken while a result waits. All state comes out of reset directly, no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_codec_digitizer_regs
    import tdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    tdr_in_if.sink           req,
    tdr_out_if.source        rsp
);

    localparam logic REG_PEN_PIN_ENABLE = 1'b0;

    logic    pen_en_reg;
    logic    cfg_write;
    logic    s1_valid;
    item_t   s1_item;
    logic    out_free;
    logic    advance;
    result_t core_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_PEN_PIN_ENABLE) ? {31'b0, pen_en_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_en_reg <= 1'b1;
        end
        else if (cfg_write && paddr[2] == REG_PEN_PIN_ENABLE)
        begin
            pen_en_reg <= pwdata[0];
        end
    end

    // an item moves on when the result register can take its transfer
    assign advance = s1_valid && out_free;

    tdr_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    tdr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (s1_item),
        .pen_pin_enable (pen_en_reg),
        .result         (core_result)
    );

    tdr_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .rsp    (rsp),
        .load   (advance),
        .result (core_result),
        .free   (out_free)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// touch codec register file and digitizer: directed and random item streams
// with random idling on both channels, pen pin enable phases over apb, and a
// scoreboard that predicts every result and checks it field by field
// ----------------------------------------------------------------------------

module tb_top;
    import tdr_pkg::*;

    localparam int         CLK_HALF      = 4;
    localparam int         IDLE_LIMIT    = 1000;
    localparam int         NUM_PHASES    = 5;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         PAUSE_PHASE   = 2;
    localparam int         PAUSE_AT      = 60;
    localparam int         HOLD_AT       = 220;
    localparam int         HOLD_CYCLES   = 64;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         QUIET_SPAN    = 40;
    localparam logic [2:0] CFG_PEN_PIN   = 3'd0;
    localparam logic [6:0] ADDR_UNKNOWN  = 7'h7f;
    localparam logic [6:0] ADDR_MASTER   = 7'h02;
    localparam logic [6:0] ADDR_GPIO_SH  = 7'h56;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         reg_addr;
        logic [15:0]        write_data;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic signed [15:0] pen_press;
        logic [1:0]         aux_pin;
        logic [15:0]        aux_mv;
    } touch_item_t;

    class codec_scoreboard;
        localparam int          AUX_VREF   = 3300;
        localparam int          AUX_FULL   = 4095;
        localparam logic [15:0] ID_RESET   = 16'h6174;
        localparam logic [15:0] ID_EXT     = 16'h0405;
        localparam logic [15:0] ID_VENDOR1 = 16'h574D;
        localparam logic [15:0] ID_VENDOR2 = 16'h4C12;

        logic [6:0]  addr_tab [26];
        logic [15:0] regs [26];
        logic [15:0] dig_ctl1;
        logic [15:0] dig_ctl2;
        logic [15:0] dig_res;
        logic [11:0] pen_smp [3];
        bit          pen_down;
        logic [11:0] aux_lvl [4];
        bit          unread;
        int unsigned queued_cnt;
        logic [15:0] queued_words [2];
        bit          pin_en;
        result_t     expected_q [$];
        int unsigned errors;

        function new();
            addr_tab = '{7'h02, 7'h04, 7'h06, 7'h0a, 7'h0e, 7'h10, 7'h14, 7'h16, 7'h18,
                         7'h1a, 7'h1c, 7'h24, 7'h26, 7'h2a, 7'h2c, 7'h2e, 7'h32, 7'h4c,
                         7'h4e, 7'h50, 7'h52, 7'h54, 7'h56, 7'h58, 7'h5a, 7'h5c};
            regs = '{16'h8000, 16'h8000, 16'h8000, 16'hc008, 16'h6808, 16'he808,
                     16'had00, 16'h8000, 16'he808, 16'h3000, 16'h8000, 16'h0000,
                     16'h0000, 16'h0410, 16'hbb80, 16'hbb80, 16'hbb80, 16'hf83e,
                     16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hf83e, 16'h0008,
                     16'h0000, 16'h0000};
            dig_ctl1 = '0;
            dig_ctl2 = '0;
            dig_res = '0;
            pen_smp = '{default: '0};
            pen_down = 1'b0;
            aux_lvl = '{default: '0};
            unread = 1'b0;
            queued_cnt = 0;
            queued_words = '{default: '0};
            pin_en = 1'b1;
            errors = 0;
        endfunction

        function int lookup(logic [6:0] a);
            for (int i = 0; i < 26; i++)
            begin
                if (addr_tab[i] == a)
                    return i;
            end
            return -1;
        endfunction

        function logic [15:0] chan_word(logic [2:0] ch);
            logic [11:0] v;
            if (ch == 3'd0)
                v = '0;
            else if (ch <= 3'd3)
                v = pen_smp[ch - 3'd1];
            else
                v = aux_lvl[ch - 3'd4];
            return {1'b0, ch, v};
        endfunction

        // one frame tick of the digitizer, returns 1 when a slot word goes out
        function bit run_tick(output logic [15:0] w);
            logic [15:0] c1;
            logic [15:0] c2;
            logic [2:0]  ch;
            c1 = dig_ctl1;
            c2 = dig_ctl2;
            w = '0;
            if (!c1[DIG1_SLOT_MODE] && unread && c2[DIG2_WAIT])
                return 1'b0;
            if (c1[DIG1_SLOT_MODE] && (c1[2:0] != 3'd0))
                return 1'b0;
            if (queued_cnt != 0)
            begin
                w = queued_words[2 - queued_cnt];
                queued_cnt--;
            end
            else if (c1[DIG1_POLL] ||
                     (c1[DIG1_CONT] && (pen_down || !c2[DIG2_PEN_DET])))
            begin
                ch = c1[DIG1_CH_LSB +: 3];
                dig_ctl1[DIG1_POLL] = 1'b0;
                if (c1[DIG1_XY])
                begin
                    w = chan_word(3'd1);
                    // y and the optional third channel follow on later ticks
                    if (ch != 3'd0)
                    begin
                        queued_words[0] = chan_word(3'd2);
                        queued_words[1] = chan_word(ch);
                        queued_cnt = 2;
                    end
                    else
                    begin
                        queued_words[1] = chan_word(3'd2);
                        queued_cnt = 1;
                    end
                end
                else
                    w = chan_word(ch);
            end
            else
                return 1'b0;
            if (dig_ctl1[DIG1_SLOT_MODE])
            begin
                w[15] = pen_down;
                return 1'b1;
            end
            dig_res = w;
            unread = 1'b1;
            return 1'b0;
        endfunction

        function void note_item(touch_item_t it);
            result_t     r;
            logic [15:0] w;
            int          idx;
            int unsigned mv;
            r = '0;
            case (it.op)
                OP_READ:
                begin
                    r.read_ok = 1'b1;
                    idx = lookup(it.reg_addr);
                    if (idx >= 0)
                        r.read_data = regs[idx];
                    else
                    begin
                        case (it.reg_addr)
                            ADDR_RESET:  r.read_data = ID_RESET;
                            ADDR_EXT_ID: r.read_data = ID_EXT;
                            ADDR_DIG1:   r.read_data = dig_ctl1;
                            ADDR_DIG2:   r.read_data = dig_ctl2;
                            ADDR_DIGRES:
                            begin
                                r.read_data = {pen_down, dig_res[14:0]};
                                unread = 1'b0;
                            end
                            ADDR_VID1:   r.read_data = ID_VENDOR1;
                            ADDR_VID2:   r.read_data = ID_VENDOR2;
                            default:     r.read_ok = 1'b0;
                        endcase
                    end
                end
                OP_WRITE:
                begin
                    idx = lookup(it.reg_addr);
                    if (idx >= 0)
                        regs[idx] = it.write_data;
                    else if (it.reg_addr == ADDR_DIG1)
                        dig_ctl1 = it.write_data;
                    else if (it.reg_addr == ADDR_DIG2)
                        dig_ctl2 = it.write_data;
                end
                OP_TICK:
                begin
                    if (run_tick(w))
                    begin
                        r.slot_valid = 1'b1;
                        r.slot_data = w;
                    end
                end
                OP_PEN:
                begin
                    if (!it.pen_x[15] && !it.pen_y[15] && !it.pen_press[15])
                    begin
                        pen_smp[0] = it.pen_x[11:0];
                        pen_smp[1] = it.pen_y[11:0];
                        pen_smp[2] = it.pen_press[11:0];
                        pen_down = 1'b1;
                    end
                    else
                    begin
                        // pen up: x and y full scale, no pressure
                        pen_smp[0] = 12'hfff;
                        pen_smp[1] = 12'hfff;
                        pen_smp[2] = 12'h000;
                        pen_down = 1'b0;
                    end
                end
                OP_AUX:
                begin
                    mv = it.aux_mv;
                    if (mv > AUX_VREF)
                        aux_lvl[it.aux_pin] = 12'hfff;
                    else
                        aux_lvl[it.aux_pin] = 12'((mv * AUX_FULL + AUX_VREF / 2) / AUX_VREF);
                end
                default: ;
            endcase
            r.pen_pin_level = pin_en && !regs[GPIOSHARE_SLOT][GPIO_PEN_SHARE] && pen_down;
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.read_data !== exp_r.read_data)
            begin
                $error("read_data: expected %h, got %h", exp_r.read_data, got.read_data);
                errors++;
            end
            if (got.read_ok !== exp_r.read_ok)
            begin
                $error("read_ok: expected %b, got %b", exp_r.read_ok, got.read_ok);
                errors++;
            end
            if (got.slot_valid !== exp_r.slot_valid)
            begin
                $error("slot_valid: expected %b, got %b", exp_r.slot_valid, got.slot_valid);
                errors++;
            end
            if (got.slot_data !== exp_r.slot_data)
            begin
                $error("slot_data: expected %h, got %h", exp_r.slot_data, got.slot_data);
                errors++;
            end
            if (got.pen_pin_level !== exp_r.pen_pin_level)
            begin
                $error("pen_pin_level: expected %b, got %b",
                       exp_r.pen_pin_level, got.pen_pin_level);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tdr_in_if  req_ch ();
    tdr_out_if rsp_ch ();

    codec_scoreboard sb;
    int unsigned     send_count;
    bit              send_quiet;

    touch_codec_digitizer_regs dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic touch_item_t plain_item(logic [2:0] op, logic [6:0] a,
                                               logic [15:0] d);
        touch_item_t it;
        it = '0;
        it.op = op;
        it.reg_addr = a;
        it.write_data = d;
        return it;
    endfunction

    // mostly meaningful traffic with random content, some noise
    function automatic touch_item_t random_item();
        touch_item_t it;
        int          sel;
        it.op = 3'($urandom);
        it.reg_addr = 7'($urandom);
        it.write_data = 16'($urandom);
        it.pen_x = 16'($urandom);
        it.pen_y = 16'($urandom);
        it.pen_press = 16'($urandom);
        it.aux_pin = 2'($urandom);
        it.aux_mv = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30)
            it.op = OP_TICK;
        else if (sel < 45)
        begin
            it.op = OP_READ;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: it.reg_addr = sb.addr_tab[$urandom_range(0, 25)];
                4:          it.reg_addr = ADDR_DIGRES;
                5:          it.reg_addr = ADDR_DIG1;
                6:          it.reg_addr = ADDR_DIG2;
                7:
                begin
                    case ($urandom_range(0, 3))
                        0:       it.reg_addr = ADDR_RESET;
                        1:       it.reg_addr = ADDR_EXT_ID;
                        2:       it.reg_addr = ADDR_VID1;
                        default: it.reg_addr = ADDR_VID2;
                    endcase
                end
                default: ;
            endcase
        end
        else if (sel < 65)
        begin
            it.op = OP_WRITE;
            case ($urandom_range(0, 4))
                0, 1:
                begin
                    it.reg_addr = ADDR_DIG1;
                    // keep the slot field at zero most of the time so slot mode runs
                    if ($urandom_range(0, 4) != 0)
                        it.write_data[2:0] = 3'd0;
                end
                2:       it.reg_addr = ADDR_DIG2;
                3:       it.reg_addr = sb.addr_tab[$urandom_range(0, 25)];
                default: ;
            endcase
        end
        else if (sel < 78)
        begin
            it.op = OP_PEN;
            if ($urandom_range(0, 4) != 0)
            begin
                it.pen_x[15] = 1'b0;
                it.pen_y[15] = 1'b0;
                it.pen_press[15] = 1'b0;
            end
        end
        else if (sel < 90)
        begin
            it.op = OP_AUX;
            if ($urandom_range(0, 3) != 0)
                it.aux_mv = 16'($urandom_range(0, 3300));
        end
        else if (sel >= 95)
            it.op = 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic send_item(touch_item_t it);
        int gap;
        if (send_count % QUIET_SPAN == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= it.op;
        req_ch.reg_addr <= it.reg_addr;
        req_ch.write_data <= it.write_data;
        req_ch.pen_x <= it.pen_x;
        req_ch.pen_y <= it.pen_y;
        req_ch.pen_press <= it.pen_press;
        req_ch.aux_pin <= it.aux_pin;
        req_ch.aux_millivolts <= it.aux_mv;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_item(it);
        send_count++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pen_pin(logic v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_PEN_PIN;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.pin_en = v;
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int      gap;
        int      seen;
        bit      quiet;
        result_t got;
        seen = 0;
        quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (seen % QUIET_SPAN == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 7);
            if (seen == HOLD_AT)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.read_data = rsp_ch.read_data;
            got.read_ok = rsp_ch.read_ok;
            got.slot_valid = rsp_ch.slot_valid;
            got.slot_data = rsp_ch.slot_data;
            got.pen_pin_level = rsp_ch.pen_pin_level;
            sb.check_result(got);
            seen++;
        end
    end

    // ends the run when no transfer happens on either channel for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        touch_item_t it;
        logic        cfg;
        sb = new();
        send_count = 0;
        send_quiet = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.op = '0;
        req_ch.reg_addr = '0;
        req_ch.write_data = '0;
        req_ch.pen_x = '0;
        req_ch.pen_y = '0;
        req_ch.pen_press = '0;
        req_ch.aux_pin = '0;
        req_ch.aux_millivolts = '0;
        rsp_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_pen_pin(1'b1);

        // fixed ids, unknown address, store write and read-only write
        send_item(plain_item(OP_READ, ADDR_RESET, '0));
        send_item(plain_item(OP_READ, ADDR_VID2, '0));
        send_item(plain_item(OP_READ, ADDR_UNKNOWN, '0));
        send_item(plain_item(OP_WRITE, ADDR_MASTER, 16'hffff));
        send_item(plain_item(OP_READ, ADDR_MASTER, '0));
        send_item(plain_item(OP_WRITE, ADDR_RESET, 16'h1234));
        // pen down at the top of the range, aux extremes
        it = plain_item(OP_PEN, '0, '0);
        it.pen_x = 16'sh7fff;
        it.pen_y = 16'sh7fff;
        it.pen_press = 16'sh7fff;
        send_item(it);
        it = plain_item(OP_AUX, '0, '0);
        it.aux_pin = 2'd3;
        it.aux_mv = 16'hffff;
        send_item(it);
        it.aux_pin = 2'd0;
        it.aux_mv = 16'd3300;
        send_item(it);
        it.aux_pin = 2'd1;
        it.aux_mv = 16'd3301;
        send_item(it);
        it.aux_pin = 2'd2;
        it.aux_mv = 16'd0;
        send_item(it);
        // polled x/y set with pressure into the slot
        send_item(plain_item(OP_WRITE, ADDR_DIG1, 16'hb808));
        send_item(plain_item(OP_TICK, '0, '0));
        send_item(plain_item(OP_TICK, '0, '0));
        send_item(plain_item(OP_TICK, '0, '0));
        // slot mode with another slot selected: tick does nothing
        send_item(plain_item(OP_WRITE, ADDR_DIG1, 16'h000d));
        send_item(plain_item(OP_TICK, '0, '0));
        // register mode, then a blocked tick while the result is unread
        send_item(plain_item(OP_WRITE, ADDR_DIG2, 16'h0200));
        send_item(plain_item(OP_WRITE, ADDR_DIG1, 16'hc000));
        send_item(plain_item(OP_TICK, '0, '0));
        send_item(plain_item(OP_WRITE, ADDR_DIG1, 16'h5400));
        send_item(plain_item(OP_TICK, '0, '0));
        send_item(plain_item(OP_READ, ADDR_DIGRES, '0));
        // pen up with pen detect: continuous sampling stays quiet
        it = plain_item(OP_PEN, '0, '0);
        it.pen_x = 16'sh8000;
        send_item(it);
        send_item(plain_item(OP_WRITE, ADDR_DIG2, 16'h0800));
        send_item(plain_item(OP_WRITE, ADDR_DIG1, 16'h1408));
        send_item(plain_item(OP_TICK, '0, '0));
        // pin shared with gpio, pen down again at zero
        send_item(plain_item(OP_WRITE, ADDR_GPIO_SH, 16'h0008));
        send_item(plain_item(OP_PEN, '0, '0));
        send_item(plain_item(3'd7, '0, '0));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cfg = (ph < 4) ? 1'(ph) : 1'($urandom_range(0, 1));
            write_pen_pin(cfg);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender stops until every outstanding result is back
                if (ph == PAUSE_PHASE && n == PAUSE_AT)
                begin
                    req_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.expected_q.size() != 0);
                end
                send_item(random_item());
            end
            drain();
        end

        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tdr_pkg.sv
rtl/tdr_if.sv
rtl/tdr_in_stage.sv
rtl/tdr_core.sv
rtl/tdr_out_stage.sv
rtl/touch_codec_digitizer_regs.sv
tb/sv/tb_top.sv
